// File: sv/lmsd_pkg.sv
// lmsd_pkg: shared types and constants of the led matrix scan driver
// no dependencies; imported by every module of the block

package lmsd_pkg;

    // register reset values
    localparam logic [6:0] ACTIVE_WIDTH_RST = 7'd64;
    localparam logic [7:0] ON_TICKS_RST     = 8'd1;

    // top bit of each color field in the pixel word
    localparam logic [3:0] RED_MSB   = 4'd15;
    localparam logic [3:0] GREEN_MSB = 4'd11;
    localparam logic [3:0] BLUE_MSB  = 4'd7;

    // register indexes
    localparam logic REG_ACTIVE_WIDTH = 1'b0;
    localparam logic REG_ON_TICKS     = 1'b1;

    // item kinds on the input tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // scan phases
    typedef enum logic [1:0] {
        PH_SHIFT = 2'd0,
        PH_LATCH = 2'd1,
        PH_LIT   = 2'd2
    } phase_t;

    // configuration registers
    typedef struct packed {
        logic [6:0] active_width;
        logic [7:0] on_ticks;
    } cfg_t;

    // pin state of one tick, minus the color bits
    typedef struct packed {
        logic [3:0] row_addr;
        logic [2:0] plane;
        logic       shift;
        logic       latch;
        logic       oen_n;
    } scan_meta_t;

endpackage

// File: sv/lmsd_cfg_regs.sv
// lmsd_cfg_regs: apb register file with active_width and on_ticks
// depends on lmsd_pkg

module lmsd_cfg_regs
    import lmsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg, cfg_next;
    logic wr_req;

    assign pready = 1'b1;
    assign wr_req = psel & penable & pwrite & pready;

    // register write decode, word index from address bit 2
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_req) begin
            case (paddr[2])
                REG_ACTIVE_WIDTH: cfg_next.active_width = pwdata[6:0];
                REG_ON_TICKS:     cfg_next.on_ticks     = pwdata[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_width <= ACTIVE_WIDTH_RST;
            cfg_reg.on_ticks     <= ON_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb begin
        case (paddr[2])
            REG_ACTIVE_WIDTH: prdata = {25'd0, cfg_reg.active_width};
            REG_ON_TICKS:     prdata = {24'd0, cfg_reg.on_ticks};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/lmsd_frame_store.sv
// lmsd_frame_store: two pixel banks (upper and lower half rows), clear sweep after reset
// depends on lmsd_pkg

module lmsd_frame_store
    import lmsd_pkg::*;
#(
    parameter int COLUMNS = 64,
    parameter int SECTORS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_en,
    input  logic [4:0]  wr_row,
    input  logic [5:0]  wr_col,
    input  logic [15:0] wr_data,
    input  logic        rd_en,
    input  logic [((SECTORS > 1) ? $clog2(SECTORS) : 1) + ((COLUMNS > 1) ? $clog2(COLUMNS) : 1) - 1:0]
                        rd_addr,
    output logic [15:0] rd_top,
    output logic [15:0] rd_bottom,
    output logic        clearing
);

    localparam int RW    = (SECTORS > 1) ? $clog2(SECTORS) : 1;
    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;

    logic [15:0]   bank_top_reg [DEPTH];
    logic [15:0]   bank_bot_reg [DEPTH];
    logic [15:0]   rd_top_reg, rd_bot_reg;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          clearing_reg, clearing_next;

    logic [6:0]    row_w;
    logic          col_ok, row_top, row_bot;
    logic [RW-1:0] row_idx;
    logic [AW-1:0] wa;
    logic [15:0]   wd;
    logic          we_top, we_bot;

    // clear sweep, one entry of each bank per cycle
    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg) begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (&clr_cnt_reg) clearing_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end else begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    // write decode: rows below SECTORS go to the upper bank, the next SECTORS to the lower
    always_comb begin
        row_w   = {2'b00, wr_row};
        col_ok  = (int'(wr_col) < COLUMNS);
        row_top = (row_w < 7'(SECTORS));
        row_bot = !row_top && (row_w < 7'(2 * SECTORS));
        row_idx = row_top ? RW'(row_w) : RW'(row_w - 7'(SECTORS));
        if (clearing_reg) begin
            wa     = clr_cnt_reg;
            wd     = 16'd0;
            we_top = 1'b1;
            we_bot = 1'b1;
        end else begin
            wa     = {row_idx, CW'(wr_col)};
            wd     = wr_data;
            we_top = wr_en && col_ok && row_top;
            we_bot = wr_en && col_ok && row_bot;
        end
    end

    // banks with registered read; one item per cycle so write and read never share a cycle
    always_ff @(posedge aclk) begin
        if (we_top) bank_top_reg[wa] <= wd;
        if (rd_en)  rd_top_reg <= bank_top_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (we_bot) bank_bot_reg[wa] <= wd;
        if (rd_en)  rd_bot_reg <= bank_bot_reg[rd_addr];
    end

    assign rd_top    = rd_top_reg;
    assign rd_bottom = rd_bot_reg;
    assign clearing  = clearing_reg;

endmodule

// File: sv/lmsd_scan_seq.sv
// lmsd_scan_seq: sector, column, on-time and bit plane sequencer
// depends on lmsd_pkg

module lmsd_scan_seq
    import lmsd_pkg::*;
#(
    parameter int COLUMNS = 64,
    parameter int SECTORS = 16,
    parameter int PLANES  = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       tick,
    input  cfg_t       cfg,
    output logic [((SECTORS > 1) ? $clog2(SECTORS) : 1) + ((COLUMNS > 1) ? $clog2(COLUMNS) : 1) - 1:0]
                       rd_addr,
    output scan_meta_t meta
);

    localparam int RW = (SECTORS > 1) ? $clog2(SECTORS) : 1;
    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int PW = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int EW = ($clog2(COLUMNS + 1) > 7) ? $clog2(COLUMNS + 1) : 7;

    phase_t        phase_reg, phase_next;
    logic [RW-1:0] sector_reg, sector_next;
    logic [CW-1:0] column_reg, column_next;
    logic [7:0]    on_count_reg, on_count_next;
    logic [PW-1:0] plane_reg, plane_next;

    logic [EW-1:0] aw_ext, eff, col_inc;
    logic [7:0]    oc_inc;
    logic          sec_wrap;
    logic [RW-1:0] sector_adv;
    logic [PW-1:0] plane_adv;

    // effective width and end-of-sector values
    always_comb begin
        aw_ext = EW'(cfg.active_width);
        if (aw_ext == '0)                eff = EW'(1);
        else if (aw_ext > EW'(COLUMNS))  eff = EW'(COLUMNS);
        else                             eff = aw_ext;
        col_inc    = EW'(column_reg) + EW'(1);
        oc_inc     = on_count_reg + 8'd1;
        sec_wrap   = (sector_reg == RW'(SECTORS - 1));
        sector_adv = sec_wrap ? '0 : sector_reg + RW'(1);
        if (!sec_wrap)                        plane_adv = plane_reg;
        else if (plane_reg == PW'(PLANES - 1)) plane_adv = '0;
        else                                  plane_adv = plane_reg + PW'(1);
    end

    // next state
    always_comb begin
        phase_next    = phase_reg;
        sector_next   = sector_reg;
        column_next   = column_reg;
        on_count_next = on_count_reg;
        plane_next    = plane_reg;
        if (tick) begin
            case (phase_reg)
                PH_LATCH: begin
                    on_count_next = 8'd0;
                    if (cfg.on_ticks == 8'd0) begin
                        phase_next  = PH_SHIFT;
                        sector_next = sector_adv;
                        plane_next  = plane_adv;
                        column_next = '0;
                    end else begin
                        phase_next = PH_LIT;
                    end
                end
                PH_LIT: begin
                    on_count_next = oc_inc;
                    if (oc_inc == 8'd0 || oc_inc >= cfg.on_ticks) begin
                        phase_next    = PH_SHIFT;
                        sector_next   = sector_adv;
                        plane_next    = plane_adv;
                        column_next   = '0;
                        on_count_next = 8'd0;
                    end
                end
                default: begin
                    if (col_inc >= eff) begin
                        column_next = '0;
                        phase_next  = PH_LATCH;
                    end else begin
                        column_next = CW'(col_inc);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SHIFT;
            sector_reg   <= '0;
            column_reg   <= '0;
            on_count_reg <= 8'd0;
            plane_reg    <= '0;
        end else begin
            phase_reg    <= phase_next;
            sector_reg   <= sector_next;
            column_reg   <= column_next;
            on_count_reg <= on_count_next;
            plane_reg    <= plane_next;
        end
    end

    // outputs of the current state
    always_comb begin
        rd_addr       = {sector_reg, column_reg};
        meta.row_addr = 4'(sector_reg);
        meta.plane    = 3'(plane_reg);
        meta.shift    = 1'b0;
        meta.latch    = 1'b0;
        meta.oen_n    = 1'b1;
        case (phase_reg)
            PH_LATCH: meta.latch = 1'b1;
            PH_LIT:   meta.oen_n = 1'b0;
            default:  meta.shift = 1'b1;
        endcase
    end

endmodule

// File: sv/led_matrix_scan_driver_top.sv
// led_matrix_scan_driver_top: stream front end, read pipeline and pin state output
// depends on lmsd_pkg, lmsd_cfg_regs, lmsd_frame_store, lmsd_scan_seq
//
// Refresh engine for a HUB75-style panel of 2*SECTORS rows by COLUMNS columns. Input items
// carry either a pixel write (tuser 0) or a scan tick (tuser 1); each tick yields one pin state
// on the m_ stream, writes yield nothing. One item is taken per clock when the output is not
// stalled; a tick's pin state passes the frame store read register and then the output
// register. After reset the frame store is cleared by a sweep over all
// 2**(clog2(SECTORS)+clog2(COLUMNS)) entries, 1024 at the default size, during which s_tready
// stays low; register writes are taken at all times. Registers: active_width at 0x0, on_ticks
// at 0x4; they are to be written only while the stream is idle, which the block does not enforce.

module led_matrix_scan_driver_top
    import lmsd_pkg::*;
#(
    parameter int COLUMNS = 64,
    parameter int SECTORS = 16,
    parameter int PLANES  = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_row[4:0], pixel_col[10:5], pixel_color[26:11]
    input  logic        s_tuser,   // cmd
    // pin state stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // row_address[3:0], red_top[4], green_top[5], blue_top[6],
                                   // red_bottom[7], green_bottom[8], blue_bottom[9],
                                   // shift_strobe[10], latch_strobe[11], output_enable_n[12]
);

    localparam int AW = ((SECTORS > 1) ? $clog2(SECTORS) : 1) +
                        ((COLUMNS > 1) ? $clog2(COLUMNS) : 1);

    cfg_t          cfg;
    logic          clearing;
    logic          s_fire, tick_fire, wr_fire, p1_adv;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_top, rd_bottom;
    scan_meta_t    meta;

    scan_meta_t    p1_meta_reg, p1_meta_next;
    logic          p1_valid_reg, p1_valid_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [15:0]   m_tdata_reg, m_tdata_next;
    logic [5:0]    colors;

    function automatic logic plane_bit(input logic [15:0] w, input logic [3:0] msb,
                                       input logic [2:0] pl);
        logic [3:0] pos;
        pos = msb - {1'b0, pl};
        return w[pos];
    endfunction

    lmsd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lmsd_frame_store #(
        .COLUMNS (COLUMNS),
        .SECTORS (SECTORS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_fire),
        .wr_row    (s_tdata[4:0]),
        .wr_col    (s_tdata[10:5]),
        .wr_data   (s_tdata[26:11]),
        .rd_en     (tick_fire),
        .rd_addr   (rd_addr),
        .rd_top    (rd_top),
        .rd_bottom (rd_bottom),
        .clearing  (clearing)
    );

    lmsd_scan_seq #(
        .COLUMNS (COLUMNS),
        .SECTORS (SECTORS),
        .PLANES  (PLANES)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (tick_fire),
        .cfg     (cfg),
        .rd_addr (rd_addr),
        .meta    (meta)
    );

    // handshake: the read stage holds while the output register is full and stalled
    assign p1_adv    = !m_tvalid_reg || m_tready;
    assign s_tready  = !clearing && (!p1_valid_reg || p1_adv);
    assign s_fire    = s_tvalid && s_tready;
    assign tick_fire = s_fire && (s_tuser == CMD_TICK);
    assign wr_fire   = s_fire && (s_tuser == CMD_WRITE);

    // color bits of the current plane, zero outside the shift phase
    always_comb begin
        colors[0] = plane_bit(rd_top,    RED_MSB,   p1_meta_reg.plane);
        colors[1] = plane_bit(rd_top,    GREEN_MSB, p1_meta_reg.plane);
        colors[2] = plane_bit(rd_top,    BLUE_MSB,  p1_meta_reg.plane);
        colors[3] = plane_bit(rd_bottom, RED_MSB,   p1_meta_reg.plane);
        colors[4] = plane_bit(rd_bottom, GREEN_MSB, p1_meta_reg.plane);
        colors[5] = plane_bit(rd_bottom, BLUE_MSB,  p1_meta_reg.plane);
        if (!p1_meta_reg.shift) colors = 6'd0;
    end

    // read stage and output register
    always_comb begin
        p1_valid_next = p1_valid_reg;
        p1_meta_next  = p1_meta_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (p1_adv) begin
            m_tvalid_next = p1_valid_reg;
            m_tdata_next  = {3'b000, p1_meta_reg.oen_n, p1_meta_reg.latch, p1_meta_reg.shift,
                             colors, p1_meta_reg.row_addr};
            p1_valid_next = 1'b0;
        end
        if (tick_fire) begin
            p1_valid_next = 1'b1;
            p1_meta_next  = meta;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p1_meta_reg <= p1_meta_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // no request taken while the clear sweep runs
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_tready)
        else $error("input taken during frame store clear");

    // shift, latch and lit are exclusive
    a_one_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones({m_tdata[10], m_tdata[11], !m_tdata[12]}) == 1)
        else $error("pin state shows more than one phase");

    // color lines quiet outside the shift phase
    a_colors_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[10]) |-> (m_tdata[9:4] == 6'd0))
        else $error("color data outside shift phase");

    // a stalled read stage keeps its item
    a_p1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p1_adv) |=> (p1_valid_reg && $stable(p1_meta_reg)))
        else $error("read stage lost an item under stall");

endmodule
